@@ hw/rtl/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants of the LRU key-value cache
// Command codes, configuration width and the control bundle passed from the
// request pipeline to the entry store.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // Width of the capacity register and its reset value.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lrukv_cmd_e;

  // Control from the pipeline to the store for the item in the input register.
  typedef struct packed {
    logic       exec;  // item is processed at this edge
    lrukv_cmd_e cmd;
  } lrukv_ctl_t;

endpackage

@@ hw/rtl/lrukv_if.sv @@
// ----------------------------------------------------------------------------
// lrukv_if: valid/ready channels of the LRU key-value cache
// Request, response and configuration write channels.
// ----------------------------------------------------------------------------
interface lrukv_req_if
  import lrukv_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  lrukv_cmd_e            cmd;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lrukv_rsp_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lrukv_cfg_if
  import lrukv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lrukv_store.sv @@
// ----------------------------------------------------------------------------
// lrukv_store: entry array with parallel key match and recency ranks
// Looks up one item per cycle and applies the get/put/insert/evict update when exec is set.
// ----------------------------------------------------------------------------
module lrukv_store
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrukv_ctl_t            ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [CAP_W-1:0]      capacity_i,
  output logic                  found_o,
  output logic [VALUE_BITS-1:0] read_value_o
);

  localparam int unsigned RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [RW-1:0]         rank_q [ENTRIES];
  logic [RW-1:0]         rank_d [ENTRIES];
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [VALUE_BITS-1:0] val_q  [ENTRIES];
  logic [CW-1:0]         count_q, count_d;

  logic [ENTRIES-1:0]    hit_vec, victim_vec, kept_vec, free_oh;
  logic [RW-1:0]         hit_rank, lru_rank;
  logic [VALUE_BITS-1:0] hit_val;
  logic [CAP_W-1:0]      cap_lim;
  logic                  hit, is_put, insert, evict;

  // Parallel key compare; hit data and rank are AND-OR selected.
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_val  = hit_val | val_q[i];
      end
    end
  end

  assign hit     = |hit_vec;
  assign is_put  = (ctl_i.cmd == CMD_PUT);
  assign insert  = is_put && !hit;
  assign cap_lim = (capacity_i == '0) ? CAP_W'(1) : capacity_i;
  // Full when the count reaches the capacity or the array size.
  assign evict   = insert && ((CMPW'(count_q) >= CMPW'(cap_lim)) ||
                              (count_q == CW'(ENTRIES)));
  // Ranks of live entries are 0..count-1, so the oldest holds count-1.
  assign lru_rank = RW'(count_q - CW'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = evict && valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  assign kept_vec = valid_q & ~victim_vec;
  // Lowest free slot after the eviction.
  assign free_oh  = ~kept_vec & (kept_vec + ENTRIES'(1));

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (ctl_i.exec) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
      end else if (insert) begin
        valid_d = kept_vec | free_oh;
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_oh[i] || victim_vec[i]) begin
            rank_d[i] = '0;
          end else if (kept_vec[i]) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
        if (!evict) begin
          count_d = count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Key and data storage, no reset: only read behind a valid bit.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (ctl_i.exec && is_put && (hit_vec[i] || (insert && free_oh[i]))) begin
        val_q[i] <= value_i;
      end
      if (ctl_i.exec && insert && free_oh[i]) begin
        key_q[i] <= key_i;
      end
    end
  end

  assign found_o      = hit;
  assign read_value_o = is_put ? '0 : hit_val;

  // Keys stay unique among live entries.
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("lrukv_store: key matches more than one live entry");

  // The fill count tracks the valid bits.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("lrukv_store: live count out of step with valid bits");

  // A get never changes which entries are live.
  a_get_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && !is_put) |=> $stable(valid_q))
    else $error("lrukv_store: get altered the valid bits");

  // An insert always lands in a free slot.
  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && insert) |-> $onehot(free_oh))
    else $error("lrukv_store: no free slot for insert");

endmodule

@@ hw/rtl/lrukv_pipe.sv @@
// ----------------------------------------------------------------------------
// lrukv_pipe: request input register and response register
// Two-register pipeline with valid/ready flow control on both sides.
// ----------------------------------------------------------------------------
module lrukv_pipe
  import lrukv_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lrukv_req_if.sink             req_i,
  lrukv_rsp_if.source           rsp_o,
  output lrukv_ctl_t            ctl_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  input  logic                  found_i,
  input  logic [VALUE_BITS-1:0] read_value_i
);

  logic                  in_valid_q, in_valid_d;
  lrukv_cmd_e            cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  advance, accept, exec;

  assign advance = !out_valid_q || rsp_o.ready;
  assign exec    = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign accept  = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      in_valid_d  = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_i.cmd;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    if (exec) begin
      found_q <= found_i;
      rd_q    <= read_value_i;
    end
  end

  assign ctl_o.exec = exec;
  assign ctl_o.cmd  = cmd_q;
  assign key_o      = key_q;
  assign value_o    = value_q;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.read_value = rd_q;

endmodule

@@ hw/rtl/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU replacement
// Top level: capacity register, request pipeline and entry store.
// ----------------------------------------------------------------------------
// Each request is a get or a put. Every request returns exactly one response:
// found tells whether the key was live before the request, read_value carries
// the stored data on a get hit and zero otherwise. Hits (get or put) make the
// entry most recent; a put hit overwrites the data. A put miss inserts into the
// lowest free slot, first dropping the least recent entry when the live count
// has reached the capacity (capacity 0 acts as 1, values above ENTRIES act as
// ENTRIES; lowering it below the live count evicts nothing until the next
// insert, which then replaces one entry). Throughput is one request per clock
// while the response is not held: a transfer lands in the input register, the
// key compare and recency-rank update run from there, and the result is
// registered in the output register. Backpressure on the response holds both
// registers. Valid bits clear at reset, no clearing pass is needed.
// Write capacity only while no request is in flight.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrukv_req_if.sink   req_i,
  lrukv_rsp_if.source rsp_o,
  lrukv_cfg_if.sink   cfg_i
);

  logic [CAP_W-1:0]      capacity_q;
  lrukv_ctl_t            ctl;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;

  // Capacity register: writes are always accepted, ready is tied high.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      capacity_q <= cfg_i.data;
    end
  end

  lrukv_pipe #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .ctl_o        (ctl),
    .key_o        (key),
    .value_o      (value),
    .found_i      (found),
    .read_value_i (read_value)
  );

  lrukv_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .key_i        (key),
    .value_i      (value),
    .capacity_i   (capacity_q),
    .found_o      (found),
    .read_value_o (read_value)
  );

endmodule
